[src/fvc_pkg.sv]
// shared types and constants of the frustum volume classifier
`timescale 1ns / 1ps

package fvc_pkg;

    // plane count and configuration port geometry
    localparam int NUM_PLANES = 6;
    localparam int NUM_FIXED_PLANES = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // arithmetic widths
    localparam int COORD_W = 16;
    localparam int RADIUS_W = 15;
    localparam int PROD_W = 32;
    localparam int NORMAL_FRAC = 14;
    localparam int SUM_W = 36;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_EN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_EN = 3'd7;

    // operation codes
    localparam logic [1:0] OP_BOX = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;

    // classification codes
    localparam logic [1:0] CLS_INSIDE = 2'd0;
    localparam logic [1:0] CLS_INTER = 2'd1;
    localparam logic [1:0] CLS_OUTSIDE = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    // one request on the input channel
    typedef struct packed {
        logic [1:0]          operation;
        coord_t              first_x;
        coord_t              first_y;
        coord_t              first_z;
        coord_t              second_x;
        coord_t              second_y;
        coord_t              second_z;
        logic [RADIUS_W-1:0] radius;
    } fvc_req_t;

    // one result on the result channel
    typedef struct packed {
        logic [1:0] classification;
    } fvc_res_t;

    // data handed from cell to cell
    typedef struct packed {
        coord_t              x0;
        coord_t              y0;
        coord_t              z0;
        coord_t              x1;
        coord_t              y1;
        coord_t              z1;
        logic [RADIUS_W-1:0] radius;
        logic [1:0]          cls;
    } fvc_tok_t;

    // plane write strobes for one cell
    typedef struct packed {
        logic                  plane_we;
        logic                  enable_we;
        logic [CFG_DATA_W-1:0] data;
    } fvc_cfg_t;

endpackage

[src/fvc_chan_if.sv]
// valid/ready channel carrying one payload
`timescale 1ns / 1ps

interface fvc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

[src/fvc_cell.sv]
// one plane cell: holds a plane, tests the passing volume against it
`timescale 1ns / 1ps

module fvc_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  fvc_pkg::fvc_cfg_t cfg,
    input  logic             fixed_on,
    input  logic             up_valid,
    input  fvc_pkg::fvc_tok_t up_tok,
    output logic             up_ready,
    output logic             dn_valid,
    output fvc_pkg::fvc_tok_t dn_tok,
    input  logic             dn_ready
);
    import fvc_pkg::*;

    logic [CFG_DATA_W-1:0] plane_reg;
    logic                  enable_reg;

    logic                      va_reg;
    fvc_tok_t                  tok_a_reg;
    logic signed [PROD_W-1:0]  hx_reg, hy_reg, hz_reg;
    logic signed [PROD_W-1:0]  lx_reg, ly_reg, lz_reg;

    logic                      vb_reg;
    fvc_tok_t                  tok_b_reg;

    logic en_a, en_b;
    logic signed [COORD_W-1:0] coef_a, coef_b, coef_c, coef_d;
    coord_t hx_sel, lx_sel, hy_sel, ly_sel, hz_sel, lz_sel;
    logic signed [SUM_W-1:0] d_term, r_term, hi_sum, lo_sum;
    fvc_tok_t tok_b_next;

    // plane and enable storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg  <= '0;
            enable_reg <= 1'b0;
        end
        else
        begin
            if (cfg.plane_we)
            begin
                plane_reg <= cfg.data;
            end
            if (cfg.enable_we)
            begin
                enable_reg <= cfg.data[0];
            end
        end
    end

    assign coef_a = plane_reg[15:0];
    assign coef_b = plane_reg[31:16];
    assign coef_c = plane_reg[47:32];
    assign coef_d = plane_reg[63:48];

    // stall chain: a stage moves when empty or when the next one moves
    assign en_b     = !vb_reg || dn_ready;
    assign en_a     = !va_reg || en_b;
    assign up_ready = en_a;

    // pick the corner coordinate giving the largest and smallest term per axis
    always_comb
    begin
        if (coef_a >= 0)
        begin
            hx_sel = (up_tok.x1 > up_tok.x0) ? up_tok.x1 : up_tok.x0;
            lx_sel = (up_tok.x1 > up_tok.x0) ? up_tok.x0 : up_tok.x1;
        end
        else
        begin
            hx_sel = (up_tok.x1 > up_tok.x0) ? up_tok.x0 : up_tok.x1;
            lx_sel = (up_tok.x1 > up_tok.x0) ? up_tok.x1 : up_tok.x0;
        end
        if (coef_b >= 0)
        begin
            hy_sel = (up_tok.y1 > up_tok.y0) ? up_tok.y1 : up_tok.y0;
            ly_sel = (up_tok.y1 > up_tok.y0) ? up_tok.y0 : up_tok.y1;
        end
        else
        begin
            hy_sel = (up_tok.y1 > up_tok.y0) ? up_tok.y0 : up_tok.y1;
            ly_sel = (up_tok.y1 > up_tok.y0) ? up_tok.y1 : up_tok.y0;
        end
        if (coef_c >= 0)
        begin
            hz_sel = (up_tok.z1 > up_tok.z0) ? up_tok.z1 : up_tok.z0;
            lz_sel = (up_tok.z1 > up_tok.z0) ? up_tok.z0 : up_tok.z1;
        end
        else
        begin
            hz_sel = (up_tok.z1 > up_tok.z0) ? up_tok.z0 : up_tok.z1;
            lz_sel = (up_tok.z1 > up_tok.z0) ? up_tok.z1 : up_tok.z0;
        end
    end

    // stage a: products of the normal with the selected coordinates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en_a)
        begin
            va_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && up_valid)
        begin
            tok_a_reg <= up_tok;
            hx_reg    <= coef_a * hx_sel;
            lx_reg    <= coef_a * lx_sel;
            hy_reg    <= coef_b * hy_sel;
            ly_reg    <= coef_b * ly_sel;
            hz_reg    <= coef_c * hz_sel;
            lz_reg    <= coef_c * lz_sel;
        end
    end

    // stage b: largest and smallest distance, then update the class
    assign d_term = {{(SUM_W-COORD_W-NORMAL_FRAC){coef_d[COORD_W-1]}}, coef_d,
                     {NORMAL_FRAC{1'b0}}};
    assign r_term = {{(SUM_W-RADIUS_W-NORMAL_FRAC){1'b0}}, tok_a_reg.radius,
                     {NORMAL_FRAC{1'b0}}};
    assign hi_sum = SUM_W'(hx_reg) + SUM_W'(hy_reg) + SUM_W'(hz_reg) + d_term + r_term;
    assign lo_sum = SUM_W'(lx_reg) + SUM_W'(ly_reg) + SUM_W'(lz_reg) + d_term - r_term;

    always_comb
    begin
        tok_b_next = tok_a_reg;
        if ((fixed_on || enable_reg) && (tok_a_reg.cls != CLS_OUTSIDE))
        begin
            if (hi_sum[SUM_W-1])
            begin
                tok_b_next.cls = CLS_OUTSIDE;
            end
            else if (lo_sum[SUM_W-1])
            begin
                tok_b_next.cls = CLS_INTER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (en_b)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b && va_reg)
        begin
            tok_b_reg <= tok_b_next;
        end
    end

    assign dn_valid = vb_reg;
    assign dn_tok   = tok_b_reg;

endmodule

[src/frustum_volume_classifier.sv]
// top level: configuration decode and the row of plane cells
`timescale 1ns / 1ps

// Frustum volume classifier.
// Requests arrive on the volume channel (valid/ready, accepted when both are
// high): a box (min and max corners), a sphere (center and radius) or a point,
// all Q12.4. Each request yields one classification on the result channel:
// inside, intermediate or outside against the left, right, bottom and top
// planes plus the near and far planes while enabled.
// Planes and enables are written through cfg_we / cfg_index / cfg_data, one
// register per cycle; the user must write them only while no request is in
// flight, which the block itself does not enforce. The datapath is a row of
// six plane cells, two register stages each (multiply, then sum and sign test),
// and one request is accepted every cycle while the result channel is not stalled.
// The last cell's stage is the output register. When the receiver stalls,
// stages hold their data while empty stages upstream keep filling, so the
// volume channel stays ready until the row is full.
// Reset clears all plane and enable registers to zero and empties the row.
module frustum_volume_classifier (
    input  logic                            clk,
    input  logic                            rst_n,
    fvc_chan_if.sink                        volume,
    fvc_chan_if.source                      result,
    input  logic                            cfg_we,
    input  logic [fvc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fvc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fvc_pkg::*;

    logic     chain_valid [NUM_PLANES+1];
    logic     chain_ready [NUM_PLANES+1];
    fvc_tok_t chain_tok   [NUM_PLANES+1];
    fvc_req_t req;
    fvc_res_t res;

    // shape the request into the cell token
    assign req = volume.payload;

    always_comb
    begin
        chain_tok[0].x0 = req.first_x;
        chain_tok[0].y0 = req.first_y;
        chain_tok[0].z0 = req.first_z;
        chain_tok[0].cls = CLS_INSIDE;
        case (req.operation)
            OP_BOX:
            begin
                chain_tok[0].x1     = req.second_x;
                chain_tok[0].y1     = req.second_y;
                chain_tok[0].z1     = req.second_z;
                chain_tok[0].radius = '0;
            end
            OP_SPHERE:
            begin
                chain_tok[0].x1     = req.first_x;
                chain_tok[0].y1     = req.first_y;
                chain_tok[0].z1     = req.first_z;
                chain_tok[0].radius = req.radius;
            end
            default:
            begin
                // point test, also for the unused code
                chain_tok[0].x1     = req.first_x;
                chain_tok[0].y1     = req.first_y;
                chain_tok[0].z1     = req.first_z;
                chain_tok[0].radius = '0;
            end
        endcase
    end

    assign chain_valid[0] = volume.valid;
    assign volume.ready   = chain_ready[0];

    // row of plane cells
    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_cell
        fvc_cfg_t cell_cfg;
        logic     fixed_on;

        assign fixed_on = (i < NUM_FIXED_PLANES);
        assign cell_cfg.plane_we = cfg_we &&
            (cfg_index == (REG_PLANE_LEFT + CFG_IDX_W'(i)));
        assign cell_cfg.data = cfg_data;

        if (i == int'(REG_PLANE_NEAR))
        begin : g_near
            assign cell_cfg.enable_we = cfg_we && (cfg_index == REG_NEAR_EN);
        end
        else if (i == int'(REG_PLANE_FAR))
        begin : g_far
            assign cell_cfg.enable_we = cfg_we && (cfg_index == REG_FAR_EN);
        end
        else
        begin : g_fixed
            assign cell_cfg.enable_we = 1'b0;
        end

        fvc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cell_cfg),
            .fixed_on (fixed_on),
            .up_valid (chain_valid[i]),
            .up_tok   (chain_tok[i]),
            .up_ready (chain_ready[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_tok   (chain_tok[i+1]),
            .dn_ready (chain_ready[i+1])
        );
    end

    // result channel straight from the last cell's register
    assign res.classification     = chain_tok[NUM_PLANES].cls;
    assign result.payload         = res;
    assign result.valid           = chain_valid[NUM_PLANES];
    assign chain_ready[NUM_PLANES] = result.ready;

endmodule
